// ===== sv/vertex_transform_4x4_assert.svh =====
// ----------------------------------------------------------------------------
// vertex_transform_4x4 assertion macros
// Shorthand for the concurrent checks on the transform's ports.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_4X4_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_ASSERT_SVH

// Check clocked on clk, switched off while rst is high.
`define VT4_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vt4 check failed");

// Check clocked on clk that also holds across reset.
`define VT4_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vt4 reset check failed");

`endif

// ===== sv/vt4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_pkg
// Word types and pipeline control shared by the 4x4 vertex transform.
// ----------------------------------------------------------------------------
package vt4_pkg;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_W    = 64;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned COMP_W   = 32;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
    logic               point_mode;
  } vt4_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               overflow;
  } vt4_out_t;

  // Four 32-bit components: a vertex or one matrix row.
  typedef logic [3:0][COMP_W-1:0] vt4_vec_t;

  // Per-stage advance strobes into the row datapath.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } vt4_adv_t;

endpackage

// ===== sv/vt4_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_row
// Three-stage dot product of one matrix row with the vertex, saturated.
// ----------------------------------------------------------------------------
module vt4_row #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  vt4_pkg::vt4_adv_t  adv,
  input  vt4_pkg::vt4_vec_t  coef,
  input  vt4_pkg::vt4_vec_t  vec,
  output logic signed [31:0] sat,
  output logic               ovf
);
  import vt4_pkg::*;

  localparam int SHW = 64 - FRAC_BITS;  // shifted product width
  localparam int PW  = SHW + 1;         // pair sum width
  localparam int SW  = PW + 1;          // row sum width

  logic signed [63:0]    prod [4];
  logic signed [PW-1:0]  psum [2];
  logic signed [SHW-1:0] sh   [4];
  logic signed [SW-1:0]  total;
  logic [SW-32:0]        hi;

  // Stage 1: full-width signed products.
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      for (int c = 0; c < 4; c++) begin
        prod[c] <= $signed(coef[c]) * $signed(vec[c]);
      end
    end
  end

  // Floor shift: drop the fraction bits.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sh[c] = $signed(prod[c][63:FRAC_BITS]);
    end
  end

  // Stage 2: pair sums.
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      psum[0] <= $signed({sh[0][SHW-1], sh[0]}) + $signed({sh[1][SHW-1], sh[1]});
      psum[1] <= $signed({sh[2][SHW-1], sh[2]}) + $signed({sh[3][SHW-1], sh[3]});
    end
  end

  assign total = $signed({psum[0][PW-1], psum[0]}) + $signed({psum[1][PW-1], psum[1]});
  assign hi    = total[SW-1:31];

  // Stage 3: final sum and clamp to 32 bits.
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      if (hi == '0 || hi == '1) begin
        sat <= total[31:0];
        ovf <= 1'b0;
      end else begin
        sat <= total[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        ovf <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/vertex_transform_4x4.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// Homogeneous 4x4 matrix times vertex in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Load the row-major matrix through cfg_we / cfg_index / cfg_data: register
//   2*r + c/2 holds row r, column c; bits 31:0 the even and 63:32 the odd
//   column. Write it only while the pipe is empty.
//   Vertex words enter on vtx_valid / vtx_ready; with point_mode set, in_w is
//   replaced by 1.0. Results leave on res_valid / res_ready.
//   A word accepted on vtx passes the input register, product stage,
//   pair-sum stage and sum-and-clamp stage, in that order, before it is
//   shown on res and can leave.
//   Throughput: one vertex per cycle while res_ready stays high; each stage
//   holds its own multipliers and adders, so nothing is shared between words.
//   Stall: when res_ready is low, the pipe still fills its empty stages;
//   only full stages behind the stalled output hold. vtx_ready drops once
//   every stage is full. No word is lost or repeated.
//   Reset: clears the matrix to zero and drops all stage valid bits.
//   Overflow: any row sum beyond 32 bits signed saturates and raises
//   res.overflow for that word.
// ----------------------------------------------------------------------------
module vertex_transform_4x4 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [vt4_pkg::IDX_W-1:0]             cfg_index,
  input  logic [vt4_pkg::REG_W-1:0]             cfg_data,
  input  logic                                  vtx_valid,
  output logic                                  vtx_ready,
  input  vt4_pkg::vt4_in_t                      vtx,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output vt4_pkg::vt4_out_t                     res
);
  import vt4_pkg::*;

  localparam logic [31:0] W_ONE = 32'(1) << FRAC_BITS;

  logic [REG_W-1:0] mat [NUM_REGS];

  // Stage valid bits and advance strobes.
  logic v0, v1, v2, v3;
  logic a0, a1, a2, a3;
  vt4_adv_t adv;

  vt4_vec_t vec;
  vt4_vec_t coef [4];
  logic signed [31:0] sat [4];
  logic [3:0]         ovf;

  // A stage may load when it is empty or its content moves on.
  assign a3 = !v3 || res_ready;
  assign a2 = !v2 || a3;
  assign a1 = !v1 || a2;
  assign a0 = !v0 || a1;
  assign vtx_ready = a0;

  assign adv.s1 = a1;
  assign adv.s2 = a2;
  assign adv.s3 = a3;

  // Matrix registers: the user must write them only while idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        mat[i] <= '0;
      end
    end else if (cfg_we) begin
      mat[cfg_index] <= cfg_data;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (a0) v0 <= vtx_valid;
      if (a1) v1 <= v0;
      if (a2) v2 <= v1;
      if (a3) v3 <= v2;
    end
  end

  // Input register: pick w here so the product stage sees a clean vector.
  always_ff @(posedge clk) begin
    if (a0 && vtx_valid) begin
      vec[0] <= vtx.in_x;
      vec[1] <= vtx.in_y;
      vec[2] <= vtx.in_z;
      vec[3] <= vtx.point_mode ? W_ONE : vtx.in_w;
    end
  end

  // Unpack each row's four coefficients from its two registers.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      coef[r][0] = mat[2*r][31:0];
      coef[r][1] = mat[2*r][63:32];
      coef[r][2] = mat[2*r+1][31:0];
      coef[r][3] = mat[2*r+1][63:32];
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    vt4_row #(
      .FRAC_BITS(FRAC_BITS)
    ) u_row (
      .clk (clk),
      .adv (adv),
      .coef(coef[r]),
      .vec (vec),
      .sat (sat[r]),
      .ovf (ovf[r])
    );
  end

  assign res_valid    = v3;
  assign res.out_x    = sat[0];
  assign res.out_y    = sat[1];
  assign res.out_z    = sat[2];
  assign res.out_w    = sat[3];
  assign res.overflow = |ovf;

endmodule

// ===== sv/vt4_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_check
// Port-level checks on the vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
`include "vertex_transform_4x4_assert.svh"

module vt4_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          vtx_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input vt4_pkg::vt4_out_t             res
);
  import vt4_pkg::*;

  // A stalled result word holds.
  `VT4_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res))
  // Reset empties the pipe.
  `VT4_ASSERT_RST(a_rst_empty, rst |=> !res_valid)
  // A draining output never blocks the input side.
  `VT4_ASSERT(a_flow, res_ready |-> vtx_ready)
  // Overflow only comes with a clamped component.
  `VT4_ASSERT(a_ovf_sat, res_valid && res.overflow |->
    (res.out_x == 32'sh7fff_ffff || res.out_x == 32'sh8000_0000 ||
     res.out_y == 32'sh7fff_ffff || res.out_y == 32'sh8000_0000 ||
     res.out_z == 32'sh7fff_ffff || res.out_z == 32'sh8000_0000 ||
     res.out_w == 32'sh7fff_ffff || res.out_w == 32'sh8000_0000))

endmodule

bind vertex_transform_4x4 vt4_check u_check (
  .clk      (clk),
  .rst      (rst),
  .vtx_ready(vtx_ready),
  .res_valid(res_valid),
  .res_ready(res_ready),
  .res      (res)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vertex_transform_4x4. Loads a range of matrices
// (identity, half, all-max, all-min, small, full-range, mixed extremes),
// streams directed and random vertex words through the valid/ready ports with
// random idling on both sides, and checks every result word against a
// Q16.16 matrix-times-vertex model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
  import vt4_pkg::*;

  localparam int          FRAC_BITS = 16;
  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;
  localparam logic [31:0] ONE_Q     = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE_Q = 32'hFFFF_0000;
  localparam logic [31:0] NEG_LSB   = 32'hFFFF_FFFF;
  localparam logic [31:0] HALF_Q    = 32'h0000_8000;
  localparam longint      SAT_HI    = 64'sh7FFF_FFFF;
  localparam longint      SAT_LO    = -64'sh8000_0000;
  localparam int          LONG_HOLD = 300;

  typedef enum int {
    MAT_IDENTITY,
    MAT_HALF,
    MAT_MAX,
    MAT_MIN,
    MAT_SMALL,
    MAT_FULL,
    MAT_EXTREME
  } matrix_kind_e;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the matrix registers and the queue of
  // result words still owed by the pipe.
  // --------------------------------------------------------------------------
  class transform_checker;
    logic [63:0] matrix_regs [NUM_REGS];
    vt4_out_t    owed_results [$];
    int          errors;

    function new();
      foreach (matrix_regs[i]) matrix_regs[i] = '0;
      errors = 0;
    endfunction

    function void load_reg(int idx, logic [63:0] val);
      matrix_regs[idx] = val;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Row r dot (x, y, z, w): exact 64-bit products, floor shift, exact sum,
    // then clamp to 32 bits signed.
    function vt4_out_t apply_matrix(vt4_in_t v);
      longint            comp [4];
      longint            coef;
      longint            prod;
      longint            acc;
      logic [63:0]       rg;
      logic signed [31:0] k;
      logic [31:0]       row_out [4];
      logic              ovf;
      vt4_out_t          r;
      comp[0] = $signed(v.in_x);
      comp[1] = $signed(v.in_y);
      comp[2] = $signed(v.in_z);
      if (v.point_mode) begin
        comp[3] = longint'(1) <<< FRAC_BITS;
      end else begin
        comp[3] = $signed(v.in_w);
      end
      ovf = 1'b0;
      for (int row = 0; row < 4; row++) begin
        acc = 0;
        for (int col = 0; col < 4; col++) begin
          rg   = matrix_regs[2 * row + col / 2];
          k    = (col % 2) ? rg[63:32] : rg[31:0];
          coef = k;
          prod = coef * comp[col];
          acc += prod >>> FRAC_BITS;
        end
        if (acc > SAT_HI) begin
          acc = SAT_HI;
          ovf = 1'b1;
        end else if (acc < SAT_LO) begin
          acc = SAT_LO;
          ovf = 1'b1;
        end
        row_out[row] = acc[31:0];
      end
      r.out_x    = row_out[0];
      r.out_y    = row_out[1];
      r.out_z    = row_out[2];
      r.out_w    = row_out[3];
      r.overflow = ovf;
      return r;
    endfunction

    function void note_vertex(vt4_in_t v);
      owed_results.push_back(apply_matrix(v));
    endfunction

    function void check_result(vt4_out_t got);
      vt4_out_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result word with no vertex owed: got x=%h y=%h z=%h w=%h ovf=%b",
                 $time, got.out_x, got.out_y, got.out_z, got.out_w, got.overflow);
        return;
      end
      want = owed_results.pop_front();
      if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
          got.out_z !== want.out_z || got.out_w !== want.out_w ||
          got.overflow !== want.overflow) begin
        errors++;
        $display("%0t: result mismatch: expected x=%h y=%h z=%h w=%h ovf=%b",
                 $time, want.out_x, want.out_y, want.out_z, want.out_w, want.overflow);
        $display("%0t:                  actual x=%h y=%h z=%h w=%h ovf=%b",
                 $time, got.out_x, got.out_y, got.out_z, got.out_w, got.overflow);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its ports
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [IDX_W-1:0]    cfg_index;
  logic [REG_W-1:0]    cfg_data;
  logic                vtx_valid;
  logic                vtx_ready;
  vt4_in_t             vtx;
  logic                res_valid;
  logic                res_ready;
  vt4_out_t            res;

  vertex_transform_4x4 #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  transform_checker sb = new();

  // Idling controls: the main thread flips these between phases.
  bit tx_gaps   = 1'b1;
  bit rx_stalls = 1'b1;
  bit hold_req  = 1'b0;

  logic [31:0] coef_set [16];

  // Drive every input to a known value from time zero.
  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    vtx_valid = 1'b0;
    vtx       = '0;
    res_ready = 1'b1;
  end

  always #2 clk = ~clk;

  // Generous fixed limit: far above the slowest legal run.
  initial begin
    #4_000_000;
    $display("** vertex_transform_4x4: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge. Check the outgoing
  // word first, then note the incoming one, so the queue order stays exact.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) sb.check_result(res);
      if (vtx_valid && vtx_ready) sb.note_vertex(vtx);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on
  // request that lets the pipe fill and back up into vtx_ready.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      res_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 5))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return ONE_Q;
      4:       return NEG_ONE_Q;
      default: return NEG_LSB;
    endcase
  endfunction

  // Mix full-range, moderate and integer values with the extremes.
  function automatic logic [31:0] pick_component();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom();
      2, 3:    return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      4:       return pick_extreme();
      default: return ($urandom_range(0, 16) - 8) << FRAC_BITS;
    endcase
  endfunction

  function automatic vt4_in_t mk_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic [31:0] w, logic pm);
    vt4_in_t v;
    v.in_x       = x;
    v.in_y       = y;
    v.in_z       = z;
    v.in_w       = w;
    v.point_mode = pm;
    return v;
  endfunction

  function automatic vt4_in_t random_vertex();
    return mk_vertex(pick_component(), pick_component(), pick_component(),
                     pick_component(), 1'($urandom_range(0, 1)));
  endfunction

  function automatic void fill_matrix(matrix_kind_e kind);
    for (int i = 0; i < 16; i++) begin
      case (kind)
        MAT_IDENTITY: coef_set[i] = (i / 4 == i % 4) ? ONE_Q : '0;
        MAT_HALF:     coef_set[i] = HALF_Q;
        MAT_MAX:      coef_set[i] = Q_MAX;
        MAT_MIN:      coef_set[i] = Q_MIN;
        // roughly -4.0 .. +4.0
        MAT_SMALL:    coef_set[i] = $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
        MAT_FULL:     coef_set[i] = $urandom();
        default:      coef_set[i] = pick_extreme();
      endcase
    end
  endfunction

  // Write all eight registers on back-to-back edges; register i holds
  // coefficients 2i (low half) and 2i+1 (high half).
  task automatic program_matrix(matrix_kind_e kind);
    logic [63:0] val;
    fill_matrix(kind);
    for (int i = 0; i < NUM_REGS; i++) begin
      val = {coef_set[2 * i + 1], coef_set[2 * i]};
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data  <= val;
      sb.load_reg(i, val);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one word and hold it until accepted; then maybe idle a burst.
  task automatic send_vertex(vt4_in_t v);
    @(negedge clk);
    vtx_valid <= 1'b1;
    vtx       <= v;
    do @(posedge clk); while (!vtx_ready);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      vtx_valid <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
  endtask

  // Drop valid and hold until every owed result word has come back. Every
  // vertex yields exactly one word, so an empty queue means an empty pipe.
  task automatic wait_pipe_empty();
    @(negedge clk);
    vtx_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_vertex(random_vertex());
  endtask

  task automatic run_phase(matrix_kind_e kind, int n);
    wait_pipe_empty();
    program_matrix(kind);
    send_random(n);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset matrix is all zero: any vertex maps to zero.
    send_vertex(mk_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0));
    send_vertex(mk_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));

    // Identity: extremes pass through; point flag replaces w with 1.0.
    wait_pipe_empty();
    program_matrix(MAT_IDENTITY);
    send_vertex(mk_vertex('0, '0, '0, '0, 1'b0));
    send_vertex(mk_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0));
    send_vertex(mk_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
    send_vertex(mk_vertex(Q_MAX, Q_MIN, ONE_Q, NEG_LSB, 1'b0));
    send_vertex(mk_vertex(32'h0003_0000, NEG_ONE_Q, 32'h5, 32'hDEAD_BEEF, 1'b1));
    send_vertex(mk_vertex(Q_MIN, Q_MAX, '0, Q_MIN, 1'b1));

    // Half: floor shift of -0.5 lsb gives -1 per term; all-max overflows.
    wait_pipe_empty();
    program_matrix(MAT_HALF);
    send_vertex(mk_vertex(NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB, 1'b0));
    send_vertex(mk_vertex(32'h1, 32'h1, 32'h1, 32'h1, 1'b0));
    send_vertex(mk_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0));

    // All-max coefficients: saturate high and low, and a near-cancel.
    wait_pipe_empty();
    program_matrix(MAT_MAX);
    send_vertex(mk_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0));
    send_vertex(mk_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
    send_vertex(mk_vertex(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0));
    send_vertex(mk_vertex('0, '0, '0, Q_MIN, 1'b1));
    send_vertex(mk_vertex(32'h1, '0, '0, '0, 1'b0));

    // All-min coefficients: min*min saturates high; w = 1.0 lands on the limit.
    wait_pipe_empty();
    program_matrix(MAT_MIN);
    send_vertex(mk_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
    send_vertex(mk_vertex(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 1'b1));
    send_vertex(mk_vertex('0, '0, '0, Q_MAX, 1'b1));

    // Random part. First phase carries the long receiver hold-off and a
    // sender pause that lets the pipe drain completely.
    run_phase(MAT_SMALL, 60);
    hold_req = 1'b1;
    send_random(60);
    wait_pipe_empty();
    send_random(130);

    run_phase(MAT_FULL, 250);
    run_phase(MAT_EXTREME, 250);
    run_phase(MAT_IDENTITY, 150);
    run_phase(MAT_MAX, 150);
    run_phase(MAT_MIN, 150);
    run_phase(MAT_HALF, 100);
    run_phase(MAT_SMALL, 200);

    // Last stretch at full rate: no idling on either side.
    wait_pipe_empty();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    program_matrix(MAT_FULL);
    send_random(250);

    wait_pipe_empty();
    // Wait on so that any stray word can show up.
    repeat (16) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** vertex_transform_4x4: PASSED **");
    end else begin
      $display("** vertex_transform_4x4: FAILED **");
    end
    $finish;
  end

endmodule
